/* rtl/slbc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slbc_pkg: shared types and constants for the status LED blink controller
// Event and result payloads, controller state, status and pattern codes.
// ---------------------------------------------------------------------------
package slbc_pkg;

  // Event operations
  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SET_STATUS = 2'd1,
    OP_BLINK      = 2'd2,
    OP_FIND_ME    = 2'd3
  } op_t;

  // Status codes
  localparam logic [2:0] ST_OFF        = 3'd0;
  localparam logic [2:0] ST_CONNECTING = 3'd1;
  localparam logic [2:0] ST_CONNECTED  = 3'd2;
  localparam logic [2:0] ST_READY      = 3'd3;
  localparam logic [2:0] ST_HEARTBEAT  = 3'd4;
  localparam logic [2:0] ST_WORKING    = 3'd5;

  // Pattern types
  localparam logic [2:0] PT_FEED        = 3'd0;
  localparam logic [2:0] PT_ERROR       = 3'd1;
  localparam logic [2:0] PT_SUCCESS     = 3'd2;
  localparam logic [2:0] PT_FIND_ME     = 3'd3;
  localparam logic [2:0] PT_CONNECTING  = 3'd4;
  localparam logic [2:0] PT_CONNECTED   = 3'd5;
  localparam logic [2:0] PT_UNASSIGNED  = 3'd6;
  localparam int         NUM_PATTERNS   = 7;

  // Configuration register indexes
  localparam logic [2:0] REG_INTERVAL_FEED        = 3'd0;
  localparam logic [2:0] REG_INTERVAL_ERROR       = 3'd1;
  localparam logic [2:0] REG_INTERVAL_SUCCESS     = 3'd2;
  localparam logic [2:0] REG_INTERVAL_FIND_ME     = 3'd3;
  localparam logic [2:0] REG_INTERVAL_CONNECTING  = 3'd4;
  localparam logic [2:0] REG_INTERVAL_CONNECTED   = 3'd5;
  localparam logic [2:0] REG_INTERVAL_UNASSIGNED  = 3'd6;
  localparam logic [2:0] REG_HEARTBEAT_PERIOD     = 3'd7;

  // Fixed timing constants
  localparam logic [7:0]  HEARTBEAT_PULSE = 8'd50;
  localparam logic [7:0]  WORKING_BLINKS  = 8'd3;
  localparam logic [31:0] MS_PER_SECOND   = 32'd1000;

  // Interval table, indexed by pattern type
  typedef logic [NUM_PATTERNS-1:0][15:0] interval_arr_t;

  localparam interval_arr_t INTERVAL_RESET = {
    16'd2000, 16'd1000, 16'd500, 16'd80, 16'd150, 16'd200, 16'd100
  };
  localparam logic [15:0] HEARTBEAT_PERIOD_RESET = 16'd1000;

  // Event payload
  typedef struct packed {
    op_t         operation;
    logic [2:0]  status;
    logic [2:0]  blink_type;
    logic [7:0]  blink_count;
    logic [15:0] find_me_seconds;
  } in_item_t;

  // Result payload
  typedef struct packed {
    logic       led_on;
    logic       pattern_active;
    logic [2:0] status_now;
    logic       find_me_on;
  } out_item_t;

  // Controller state
  typedef struct packed {
    logic [31:0] time_ms;
    logic [31:0] last_toggle_time;
    logic [31:0] last_heartbeat_time;
    logic [31:0] find_me_deadline;
    logic [8:0]  toggles_done;
    logic [8:0]  toggles_target;
    logic        led_level;
    logic        blinking_active;
    logic        find_me_flag;
    logic [2:0]  saved_status;
    logic [15:0] active_interval;
    logic [7:0]  pulse_remaining;
  } state_t;

  localparam state_t STATE_RESET = '{
    time_ms:             32'd0,
    last_toggle_time:    32'd0,
    last_heartbeat_time: 32'd0,
    find_me_deadline:    32'd0,
    toggles_done:        9'd0,
    toggles_target:      9'd0,
    led_level:           1'b0,
    blinking_active:     1'b0,
    find_me_flag:        1'b0,
    saved_status:        ST_OFF,
    active_interval:     16'd100,
    pulse_remaining:     8'd0
  };

endpackage

/* rtl/status_led_blink_controller.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// status_led_blink_controller: event driven status LED controller
// Each event (ms tick, status change, blink request, find-me request) updates
// the controller state in one pass and yields one result with the LED level.
// ---------------------------------------------------------------------------
// A result is registered in out_data, or in the skid entry while out_data
// holds an untaken one. Throughput: one event per cycle while the skid entry
// is empty; the state update is a single pass of compare and add logic, and
// a two-entry result buffer lets input flow while a result waits to be taken.
// Reset (synchronous, active high): state, config and flags return to defaults.
module status_led_blink_controller
  import slbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // event channel
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  interval_arr_t intervals;
  logic [15:0]   heartbeat_period;

  // Controller state
  state_t        state;
  state_t        state_next;

  // Result buffer: main register plus skid entry
  out_item_t     result_next;
  out_item_t     skid;
  logic          skid_valid;
  logic          in_xfer;
  logic          out_xfer;

  // Start a blink pattern unless it is out of range or blocked by find-me
  function automatic state_t begin_pattern(state_t s, logic [2:0] ptype,
                                           logic [7:0] blinks, interval_arr_t iv);
    state_t r;
    r = s;
    if (ptype <= PT_UNASSIGNED && !(s.find_me_flag && ptype != PT_FIND_ME)) begin
      r.blinking_active  = 1'b1;
      r.toggles_done     = 9'd0;
      r.toggles_target   = {blinks, 1'b0};
      r.last_toggle_time = s.time_ms;
      r.active_interval  = iv[ptype];
      r.led_level        = 1'b0;
      r.pulse_remaining  = 8'd0;
    end
    return r;
  endfunction

  // Record a status and start what it implies
  function automatic state_t apply_status(state_t s, logic [2:0] st,
                                          interval_arr_t iv);
    state_t r;
    r = s;
    r.saved_status = st;
    case (st)
      ST_OFF: begin
        r.blinking_active = 1'b0;
        r.led_level       = 1'b0;
        r.pulse_remaining = 8'd0;
      end
      ST_CONNECTING: r = begin_pattern(r, PT_CONNECTING, 8'd0, iv);
      ST_CONNECTED:  r = begin_pattern(r, PT_UNASSIGNED, 8'd0, iv);
      ST_READY, ST_HEARTBEAT: r.blinking_active = 1'b0;
      default:       r = begin_pattern(r, PT_FEED, WORKING_BLINKS, iv);
    endcase
    return r;
  endfunction

  // One millisecond tick
  function automatic state_t do_tick(state_t s, interval_arr_t iv,
                                     logic [15:0] hb_period);
    state_t      r;
    logic [31:0] fm_diff;
    logic [31:0] toggle_diff;
    logic [31:0] hb_diff;
    r = s;
    r.time_ms = s.time_ms + 32'd1;
    // heartbeat pulse end
    if (r.pulse_remaining != 8'd0) begin
      r.pulse_remaining = r.pulse_remaining - 8'd1;
      if (r.pulse_remaining == 8'd0) begin
        r.led_level = 1'b0;
      end
    end
    fm_diff     = r.time_ms - r.find_me_deadline;
    toggle_diff = r.time_ms - r.last_toggle_time;
    hb_diff     = r.time_ms - r.last_heartbeat_time;
    if (r.find_me_flag && !fm_diff[31]) begin
      // find-me deadline passed: restore the saved status
      r.find_me_flag    = 1'b0;
      r.blinking_active = 1'b0;
      r = apply_status(r, r.saved_status, iv);
    end else if (r.blinking_active) begin
      if (toggle_diff >= {16'd0, r.active_interval}) begin
        r.led_level        = !r.led_level;
        r.pulse_remaining  = 8'd0;
        r.toggles_done     = r.toggles_done + 9'd1;
        r.last_toggle_time = r.time_ms;
        // finite pattern done
        if (r.toggles_target != 9'd0 && r.toggles_done >= r.toggles_target) begin
          r.blinking_active = 1'b0;
          r.led_level       = 1'b0;
          if (!r.find_me_flag) begin
            r = apply_status(r, r.saved_status, iv);
          end
        end
      end
    end else if (!r.find_me_flag) begin
      if (r.saved_status inside {ST_READY, ST_HEARTBEAT}) begin
        if (hb_diff > {16'd0, hb_period}) begin
          r.led_level           = 1'b1;
          r.pulse_remaining     = HEARTBEAT_PULSE;
          r.last_heartbeat_time = r.time_ms;
        end
      end else if (r.saved_status == ST_OFF) begin
        r.led_level       = 1'b0;
        r.pulse_remaining = 8'd0;
      end
    end
    return r;
  endfunction

  // Handshakes
  assign in_stall = skid_valid;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // Event evaluation
  always_comb begin
    state_next = state;
    case (in_data.operation)
      OP_TICK: state_next = do_tick(state, intervals, heartbeat_period);
      OP_SET_STATUS: begin
        if (in_data.status <= ST_WORKING) begin
          state_next = apply_status(state, in_data.status, intervals);
        end
      end
      OP_BLINK: state_next = begin_pattern(state, in_data.blink_type,
                                           in_data.blink_count, intervals);
      OP_FIND_ME: begin
        state_next.find_me_flag     = 1'b1;
        state_next.find_me_deadline = state.time_ms +
                                      {16'd0, in_data.find_me_seconds} * MS_PER_SECOND;
        state_next = begin_pattern(state_next, PT_FIND_ME, 8'd0, intervals);
      end
      default: state_next = state;
    endcase
  end

  // Result fields
  always_comb begin
    result_next.led_on         = state_next.led_level;
    result_next.pattern_active = state_next.blinking_active;
    result_next.status_now     = state_next.saved_status;
    result_next.find_me_on     = state_next.find_me_flag;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (in_xfer) begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      intervals        <= INTERVAL_RESET;
      heartbeat_period <= HEARTBEAT_PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTERVAL_FEED:       intervals[PT_FEED]       <= cfg_data;
        REG_INTERVAL_ERROR:      intervals[PT_ERROR]      <= cfg_data;
        REG_INTERVAL_SUCCESS:    intervals[PT_SUCCESS]    <= cfg_data;
        REG_INTERVAL_FIND_ME:    intervals[PT_FIND_ME]    <= cfg_data;
        REG_INTERVAL_CONNECTING: intervals[PT_CONNECTING] <= cfg_data;
        REG_INTERVAL_CONNECTED:  intervals[PT_CONNECTED]  <= cfg_data;
        REG_INTERVAL_UNASSIGNED: intervals[PT_UNASSIGNED] <= cfg_data;
        REG_HEARTBEAT_PERIOD:    heartbeat_period         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_xfer) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_xfer;
      end
    end else if (in_xfer) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  // Result buffer data
  always_ff @(posedge clk) begin
    if (out_xfer) begin
      if (skid_valid) begin
        out_data <= skid;
      end else if (in_xfer) begin
        out_data <= result_next;
      end
    end else if (in_xfer) begin
      if (out_valid) begin
        skid <= result_next;
      end else begin
        out_data <= result_next;
      end
    end
  end

endmodule
